// ----- hdl/digitizer_event_word_decoder_defines.svh -----
// Assertion macros for the back end of the digitizer event word decoder.
`ifndef DIGITIZER_EVENT_WORD_DECODER_DEFINES_SVH
`define DIGITIZER_EVENT_WORD_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DEWD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dewd same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DEWD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dewd next-cycle check failed");

`endif

// ----- hdl/dewd_pkg.sv -----
// Types and constants shared by the digitizer event word decoder modules.
package dewd_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ChanW    = 6;
  localparam int unsigned NumChan  = 34;
  localparam int unsigned CntW     = 4;
  localparam int unsigned DataW    = 30;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned FwW      = 4;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned CigW     = 4;
  localparam int unsigned RegDataW = 32;
  localparam int unsigned PaddrW   = 3;

  localparam logic [FwW-1:0] FwSupported = 4'd2;

  localparam logic [1:0] Top2Header = 2'b01;
  localparam logic [1:0] Top2End    = 2'b11;
  localparam logic [3:0] Top4Data   = 4'b0001;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_HEADER  = 3'd1,
    ST_END     = 3'd2,
    ST_BAD     = 3'd3,
    ST_IGNORED = 3'd4,
    ST_DROPPED = 3'd5,
    ST_UNSUP   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    GRP_ADC  = 2'd0,
    GRP_TDC  = 2'd1,
    GRP_TRIG = 2'd2
  } group_e;

  // Classified word on its way from the front to the back.
  typedef struct packed {
    status_e              status;
    logic [ChanW-1:0]     chan;
    logic [DataW-1:0]     data;
  } cmd_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- hdl/dewd_queue.sv -----
// Two-entry request queue between the classifying front and the counting back.
module dewd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dewd_pkg::cmd_t  push_cmd_i,
  input  logic            pop_i,
  output dewd_pkg::cmd_t  head_o,
  output dewd_pkg::q_stat_t stat_o
);

  dewd_pkg::cmd_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

endmodule

// ----- hdl/dewd_front.sv -----
// Front end: takes readout words, tracks the event state and classifies each word.
module dewd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dewd_pkg::WordW-1:0]    word_i,
  input  logic [dewd_pkg::FwW-1:0]      fw_version_i,
  input  dewd_pkg::q_stat_t             q_stat_i,
  output logic                          push_o,
  output dewd_pkg::cmd_t                cmd_o
);

  logic                         in_event_q, in_event_d;
  logic                         accept;
  logic [1:0]                   top2;
  logic [3:0]                   top4;
  logic [dewd_pkg::ChanW-1:0]   chan;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  assign top2 = word_i[31:30];
  assign top4 = word_i[31:28];
  assign chan = word_i[21:16];

  always_comb begin
    cmd_o.status = dewd_pkg::ST_IGNORED;
    cmd_o.chan   = '0;
    cmd_o.data   = '0;
    in_event_d   = in_event_q;
    if (fw_version_i != dewd_pkg::FwSupported) begin
      cmd_o.status = dewd_pkg::ST_UNSUP;
    end else if (!in_event_q) begin
      if (top2 == dewd_pkg::Top2Header) begin
        cmd_o.status = dewd_pkg::ST_HEADER;
        in_event_d   = 1'b1;
      end else begin
        cmd_o.status = dewd_pkg::ST_BAD;
      end
    end else if (top2 == dewd_pkg::Top2End) begin
      cmd_o.status = dewd_pkg::ST_END;
      cmd_o.data   = word_i[dewd_pkg::DataW-1:0];
      in_event_d   = 1'b0;
    end else if (top4 == dewd_pkg::Top4Data &&
                 chan < dewd_pkg::ChanW'(dewd_pkg::NumChan)) begin
      // The back resolves this into a stored or a dropped hit.
      cmd_o.status = dewd_pkg::ST_HIT;
      cmd_o.chan   = chan;
      cmd_o.data   = {{(dewd_pkg::DataW - dewd_pkg::ValueW){1'b0}},
                      word_i[dewd_pkg::ValueW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_event_q <= 1'b0;
    end else if (accept) begin
      in_event_q <= in_event_d;
    end
  end

endmodule

// ----- hdl/dewd_back.sv -----
// Back end: per-channel hit counters in a memory, hit resolution and the output register.
`include "digitizer_event_word_decoder_defines.svh"

module dewd_back #(
  parameter int unsigned HIT_LIMIT = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dewd_pkg::cmd_t                 head_i,
  input  dewd_pkg::q_stat_t              q_stat_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     status_o,
  output logic [1:0]                     group_o,
  output logic [dewd_pkg::CigW-1:0]      channel_in_group_o,
  output logic [dewd_pkg::IdxW-1:0]      hit_index_o,
  output logic [dewd_pkg::ValueW-1:0]    hit_value_o,
  output logic [dewd_pkg::DataW-1:0]     timestamp_o
);

  localparam logic [dewd_pkg::CntW-1:0] HitCap = dewd_pkg::CntW'(HIT_LIMIT);

  logic [dewd_pkg::CntW-1:0]    cnt_mem [dewd_pkg::NumChan];
  logic [dewd_pkg::NumChan-1:0] vld_q;

  logic                         b_valid_q;
  dewd_pkg::cmd_t               b_cmd_q;
  logic [dewd_pkg::CntW-1:0]    b_rd_q;
  logic                         b_vld_q;
  logic                         b_hz_q, b_hz_d;
  logic [dewd_pkg::CntW-1:0]    b_hz_cnt_q, b_hz_cnt_d;

  logic                         out_valid_q;
  dewd_pkg::status_e            out_status_q, out_status_d;
  dewd_pkg::group_e             out_group_q, out_group_d;
  logic [dewd_pkg::CigW-1:0]    out_cig_q, out_cig_d;
  logic [dewd_pkg::IdxW-1:0]    out_idx_q, out_idx_d;
  logic [dewd_pkg::ValueW-1:0]  out_val_q, out_val_d;
  logic [dewd_pkg::DataW-1:0]   out_ts_q, out_ts_d;

  logic                         b_adv;
  logic [dewd_pkg::CntW-1:0]    cnt_eff;
  logic                         is_hit;
  logic                         chan_full;
  logic                         wr_en;
  logic [dewd_pkg::CntW-1:0]    wr_data;
  logic                         clr;

  assign b_adv = b_valid_q && (!out_valid_q || out_ready_i);
  assign pop_o = !q_stat_i.empty && (!b_valid_q || b_adv);

  // A read issued while the stage ahead writes the same counter, or clears
  // them all, would see the old contents; the value is forwarded instead.
  assign cnt_eff   = b_hz_q ? b_hz_cnt_q : (b_vld_q ? b_rd_q : '0);
  assign is_hit    = (b_cmd_q.status == dewd_pkg::ST_HIT);
  assign chan_full = (cnt_eff >= HitCap);
  assign wr_en     = b_adv && is_hit && !chan_full;
  assign wr_data   = cnt_eff + dewd_pkg::CntW'(1);
  assign clr       = b_adv && (b_cmd_q.status == dewd_pkg::ST_HEADER);

  always_comb begin
    b_hz_d     = clr || (wr_en && (b_cmd_q.chan == head_i.chan));
    b_hz_cnt_d = clr ? '0 : wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cnt_mem[b_cmd_q.chan] <= wr_data;
    end
    if (pop_o) begin
      b_rd_q <= cnt_mem[head_i.chan];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[b_cmd_q.chan] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (pop_o) begin
      b_valid_q <= 1'b1;
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_cmd_q    <= head_i;
      b_vld_q    <= vld_q[head_i.chan];
      b_hz_q     <= b_hz_d;
      b_hz_cnt_q <= b_hz_cnt_d;
    end
  end

  always_comb begin
    out_status_d = b_cmd_q.status;
    out_group_d  = dewd_pkg::GRP_ADC;
    out_cig_d    = '0;
    out_idx_d    = '0;
    out_val_d    = '0;
    out_ts_d     = '0;
    unique case (b_cmd_q.status)
      dewd_pkg::ST_HIT: begin
        out_status_d = chan_full ? dewd_pkg::ST_DROPPED : dewd_pkg::ST_HIT;
        if (b_cmd_q.chan[5]) begin
          out_group_d = dewd_pkg::GRP_TRIG;
        end else if (b_cmd_q.chan[4]) begin
          out_group_d = dewd_pkg::GRP_TDC;
        end
        out_cig_d = b_cmd_q.chan[dewd_pkg::CigW-1:0];
        out_idx_d = chan_full ? '0 : cnt_eff[dewd_pkg::IdxW-1:0];
        out_val_d = b_cmd_q.data[dewd_pkg::ValueW-1:0];
      end
      dewd_pkg::ST_END: begin
        out_ts_d = b_cmd_q.data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_status_q <= out_status_d;
      out_group_q  <= out_group_d;
      out_cig_q    <= out_cig_d;
      out_idx_q    <= out_idx_d;
      out_val_q    <= out_val_d;
      out_ts_q     <= out_ts_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign group_o            = out_group_q;
  assign channel_in_group_o = out_cig_q;
  assign hit_index_o        = out_idx_q;
  assign hit_value_o        = out_val_q;
  assign timestamp_o        = out_ts_q;

  `DEWD_ASSERT_IMP(a_pop_slot_free, pop_o, !b_valid_q || b_adv)
  `DEWD_ASSERT_IMP(a_cnt_bounded, wr_en, wr_data <= HitCap)
  `DEWD_ASSERT_NXT(a_header_clears, clr, vld_q == '0)

endmodule

// ----- hdl/digitizer_event_word_decoder.sv -----
// Top level of the digitizer event word decoder: configuration register and block wiring.
//
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid_i/in_ready_o   word_i
//  out       output     out_valid_o/out_ready_i status_o, group_o, channel_in_group_o,
//                                               hit_index_o, hit_value_o, timestamp_o
//  cfg       input      psel/penable/pready     paddr, pwdata, pwrite, prdata
//
// One word is taken per cycle and one result given per cycle while out_ready_i stays high.
// A word passes the queue write, the counter memory read and the output register before
// its result is valid at the output; the counter memory's one read and one write port
// set this.
// Reset leaves no event open, all hit counters at zero and the firmware version at 2.
// The two-entry queue lets the input keep taking words while the output stalls,
// until it fills; a full queue drops in_ready_o.
module digitizer_event_word_decoder #(
  parameter int unsigned HIT_LIMIT = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [dewd_pkg::WordW-1:0]        word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        status_o,
  output logic [1:0]                        group_o,
  output logic [dewd_pkg::CigW-1:0]         channel_in_group_o,
  output logic [dewd_pkg::IdxW-1:0]         hit_index_o,
  output logic [dewd_pkg::ValueW-1:0]       hit_value_o,
  output logic [dewd_pkg::DataW-1:0]        timestamp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dewd_pkg::PaddrW-1:0]       paddr,
  input  logic [dewd_pkg::RegDataW-1:0]     pwdata,
  output logic [dewd_pkg::RegDataW-1:0]     prdata,
  output logic                              pready
);

  logic [dewd_pkg::FwW-1:0] fw_q;
  logic                     reg_sel;
  logic                     push;
  logic                     pop;
  dewd_pkg::cmd_t           push_cmd;
  dewd_pkg::cmd_t           head;
  dewd_pkg::q_stat_t        q_stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[dewd_pkg::PaddrW-1] == 1'b0);
  assign prdata  = reg_sel ? {{(dewd_pkg::RegDataW - dewd_pkg::FwW){1'b0}}, fw_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= dewd_pkg::FwSupported;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      fw_q <= pwdata[dewd_pkg::FwW-1:0];
    end
  end

  dewd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_i       (word_i),
    .fw_version_i (fw_q),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  dewd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  dewd_back #(
    .HIT_LIMIT (HIT_LIMIT)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_i             (head),
    .q_stat_i           (q_stat),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .group_o            (group_o),
    .channel_in_group_o (channel_in_group_o),
    .hit_index_o        (hit_index_o),
    .hit_value_o        (hit_value_o),
    .timestamp_o        (timestamp_o)
  );

endmodule
